/* rtl/core/cbb_pkg.sv */
// shared constants and types for the circle / box boundary test core
// no dependencies; used by cbb_front, cbb_back and the top level in rtl/core
`default_nettype none

package cbb_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER_FIRST  = 2'd0;
    localparam logic [1:0] REG_CENTER_SECOND = 2'd1;
    localparam logic [1:0] REG_CIRCLE_RADIUS = 2'd2;
    localparam logic [1:0] REG_CYLINDER_AXIS = 2'd3;

    // cylinder axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // per-box flags worked out by the front end
    typedef struct packed {
        logic contained;  // circle strictly inside the rectangle
        logic between_x;  // center first coordinate within the first bounds pair
        logic between_y;  // center second coordinate within the second bounds pair
        logic dx_nz;      // horizontal edges have nonzero length
        logic dy_nz;      // vertical edges have nonzero length
    } flags_t;

endpackage

`default_nettype wire

/* rtl/core/cbb_fifo.sv */
// small synchronous queue with a fill count
// no package dependencies
`default_nettype none

module cbb_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           data_in,
    output logic                            full,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                data_out,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign count    = cnt_reg;
    assign wr_en    = push && !full;
    assign rd_en    = pop && !empty;
    assign data_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cbb_front.sv */
// front end: picks the in-plane bounds, forms center offsets and flags
// depends on cbb_pkg
`default_nettype none

module cbb_front #(
    parameter int COORD_WIDTH = cbb_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic [COORD_WIDTH-1:0] center_first,
    input  wire logic [COORD_WIDTH-1:0] center_second,
    input  wire logic [COORD_WIDTH-2:0] circle_radius,
    input  wire logic [1:0]             cylinder_axis,
    input  wire logic [COORD_WIDTH-1:0] box_x_low,
    input  wire logic [COORD_WIDTH-1:0] box_x_high,
    input  wire logic [COORD_WIDTH-1:0] box_y_low,
    input  wire logic [COORD_WIDTH-1:0] box_y_high,
    input  wire logic [COORD_WIDTH-1:0] box_z_low,
    input  wire logic [COORD_WIDTH-1:0] box_z_high,
    output logic [4*(COORD_WIDTH+1)+$bits(cbb_pkg::flags_t)-1:0] record
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] lo0, hi0, lo1, hi1;
    logic signed [W-1:0] cx, cy;
    logic signed [W:0]   dxl, dxh, dyl, dyh;
    logic signed [W+1:0] cx_e, cy_e, r_e;
    cbb_pkg::flags_t     flags;

    always_comb
    begin
        unique case (cylinder_axis)
            cbb_pkg::AXIS_X:
            begin
                lo0 = box_y_low;
                hi0 = box_y_high;
                lo1 = box_z_low;
                hi1 = box_z_high;
            end
            cbb_pkg::AXIS_Y:
            begin
                lo0 = box_x_low;
                hi0 = box_x_high;
                lo1 = box_z_low;
                hi1 = box_z_high;
            end
            default:
            begin
                lo0 = box_x_low;
                hi0 = box_x_high;
                lo1 = box_y_low;
                hi1 = box_y_high;
            end
        endcase
    end

    assign cx = center_first;
    assign cy = center_second;

    assign dxl = {lo0[W-1], lo0} - {cx[W-1], cx};
    assign dxh = {hi0[W-1], hi0} - {cx[W-1], cx};
    assign dyl = {lo1[W-1], lo1} - {cy[W-1], cy};
    assign dyh = {hi1[W-1], hi1} - {cy[W-1], cy};

    assign cx_e = {{2{cx[W-1]}}, cx};
    assign cy_e = {{2{cy[W-1]}}, cy};
    assign r_e  = {3'b000, circle_radius};

    always_comb
    begin
        flags.contained = (cx_e - r_e > $signed({{2{lo0[W-1]}}, lo0}))
                       && (cx_e + r_e < $signed({{2{hi0[W-1]}}, hi0}))
                       && (cy_e - r_e > $signed({{2{lo1[W-1]}}, lo1}))
                       && (cy_e + r_e < $signed({{2{hi1[W-1]}}, hi1}));
        // an edge segment spans the center's projection in either bound order
        flags.between_x = (lo0 <= cx && cx <= hi0) || (hi0 <= cx && cx <= lo0);
        flags.between_y = (lo1 <= cy && cy <= hi1) || (hi1 <= cy && cy <= lo1);
        flags.dx_nz     = (lo0 != hi0);
        flags.dy_nz     = (lo1 != hi1);
    end

    assign record = {flags, dyh, dyl, dxh, dxl};

endmodule

`default_nettype wire

/* rtl/core/cbb_back.sv */
// back end: squares the offsets, decides the boundary test, queues results
// depends on cbb_pkg and cbb_fifo
`default_nettype none

module cbb_back #(
    parameter int COORD_WIDTH = cbb_pkg::COORD_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = cbb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [4*(COORD_WIDTH+1)+$bits(cbb_pkg::flags_t)-1:0] record,
    input  wire logic                   rec_empty,
    output logic                        rec_pop,
    input  wire logic [COORD_WIDTH-2:0] circle_radius,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        boundary_hit
);

    localparam int W     = COORD_WIDTH;
    localparam int SQ_W  = 2 * W + 1;
    localparam int RR_W  = 2 * W - 2;
    localparam int SUM_W = 2 * W + 2;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [W:0]     dxl, dxh, dyl, dyh;
    cbb_pkg::flags_t       flags;

    logic signed [2*W+1:0] p_xl, p_xh, p_yl, p_yh;
    logic [RR_W-1:0]       r_ext;
    logic                  s1_valid_reg, s1_valid_next;
    logic [SQ_W-1:0]       sq_xl_reg, sq_xh_reg, sq_yl_reg, sq_yh_reg;
    logic [RR_W-1:0]       rr_reg;
    cbb_pkg::flags_t       flags_reg;

    logic [SUM_W-1:0]      d_ll, d_hl, d_lh, d_hh, rr_e;
    logic                  any_neg, any_pos;
    logic                  out_ll, out_hl, out_lh, out_hh;
    logic                  near_xl, near_xh, near_yl, near_yh;
    logic                  edge_hit, hit;

    logic                  res_full;
    logic [CNT_W-1:0]      res_count;

    assign {flags, dyh, dyl, dxh, dxl} = record;

    // keep room in the result queue for everything in flight
    assign rec_pop = !rec_empty
        && (({1'b0, res_count} + (CNT_W+1)'(s1_valid_reg)) < (CNT_W+1)'(QUEUE_DEPTH));
    assign s1_valid_next = rec_pop;

    assign p_xl = dxl * dxl;
    assign p_xh = dxh * dxh;
    assign p_yl = dyl * dyl;
    assign p_yh = dyh * dyh;
    assign r_ext = {{(W-1){1'b0}}, circle_radius};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            sq_xl_reg <= p_xl[SQ_W-1:0];
            sq_xh_reg <= p_xh[SQ_W-1:0];
            sq_yl_reg <= p_yl[SQ_W-1:0];
            sq_yh_reg <= p_yh[SQ_W-1:0];
            rr_reg    <= r_ext * r_ext;
            flags_reg <= flags;
        end
    end

    always_comb
    begin
        rr_e = {4'b0000, rr_reg};
        // corner names: first letter first axis bound, second letter second axis bound
        d_ll = {1'b0, sq_xl_reg} + {1'b0, sq_yl_reg};
        d_hl = {1'b0, sq_xh_reg} + {1'b0, sq_yl_reg};
        d_lh = {1'b0, sq_xl_reg} + {1'b0, sq_yh_reg};
        d_hh = {1'b0, sq_xh_reg} + {1'b0, sq_yh_reg};

        out_ll = d_ll > rr_e;
        out_hl = d_hl > rr_e;
        out_lh = d_lh > rr_e;
        out_hh = d_hh > rr_e;

        any_neg = (d_ll < rr_e) || (d_hl < rr_e) || (d_lh < rr_e) || (d_hh < rr_e);
        any_pos = out_ll || out_hl || out_lh || out_hh;

        // distance from center to each edge line, squared
        near_xl = {1'b0, sq_xl_reg} < rr_e;
        near_xh = {1'b0, sq_xh_reg} < rr_e;
        near_yl = {1'b0, sq_yl_reg} < rr_e;
        near_yh = {1'b0, sq_yh_reg} < rr_e;

        edge_hit = (flags_reg.dy_nz && near_xl && flags_reg.between_y && (out_ll || out_lh))
                || (flags_reg.dy_nz && near_xh && flags_reg.between_y && (out_hl || out_hh))
                || (flags_reg.dx_nz && near_yl && flags_reg.between_x && (out_ll || out_hl))
                || (flags_reg.dx_nz && near_yh && flags_reg.between_x && (out_lh || out_hh));

        hit = (any_neg && any_pos) || flags_reg.contained || edge_hit;
    end

    cbb_fifo #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s1_valid_reg),
        .data_in  (hit),
        .full     (res_full),
        .pop      (pop),
        .data_out (boundary_hit),
        .empty    (empty),
        .count    (res_count)
    );

`ifndef SYNTH
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !res_full)
        else $error("result queue written while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> !rec_empty)
        else $error("record queue popped while empty");

    a_stage_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |=> s1_valid_reg)
        else $error("square stage lost a record");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, res_count} + (CNT_W+1)'(s1_valid_reg)) <= (CNT_W+1)'(QUEUE_DEPTH))
        else $error("results in flight exceed queue room");
`endif

endmodule

`default_nettype wire

/* rtl/core/circle_box_boundary_test_core.sv */
// top level of the circle / box boundary test core
// depends on cbb_pkg, cbb_fifo, cbb_front and cbb_back
//
// usage:
//   input queue: drive the six box bounds and raise push; a box is taken at a
//   clock edge with push high and full low; one box per cycle while not full.
//   result queue: while empty is low, boundary_hit holds the oldest result;
//   it is taken at an edge with pop high. results leave in box order.
//   configuration: cfg_write with cfg_index and cfg_data updates one register
//   at the clock edge; write only while no box is in flight.
// flow: a taken box goes through the record queue, the square stage register
//   and the result queue; with the result side popping every cycle the core
//   sustains one box per cycle, the rate of the back-end square stage.
// stalls: the front end writes classified boxes into a record queue, the back
//   end pops them only when the result queue has room, so a stalled receiver
//   fills the result queue, then the record queue, then full rises.
// reset: both queues empty, center and radius zero, cylinder axis z.
`default_nettype none

module circle_box_boundary_test_core #(
    parameter int COORD_WIDTH = cbb_pkg::COORD_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = cbb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [COORD_WIDTH-1:0] cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [COORD_WIDTH-1:0] box_x_low,
    input  wire logic [COORD_WIDTH-1:0] box_x_high,
    input  wire logic [COORD_WIDTH-1:0] box_y_low,
    input  wire logic [COORD_WIDTH-1:0] box_y_high,
    input  wire logic [COORD_WIDTH-1:0] box_z_low,
    input  wire logic [COORD_WIDTH-1:0] box_z_high,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        boundary_hit
);

    localparam int REC_W = 4 * (COORD_WIDTH + 1) + $bits(cbb_pkg::flags_t);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COORD_WIDTH-1:0] center_first_reg, center_first_next;
    logic [COORD_WIDTH-1:0] center_second_reg, center_second_next;
    logic [COORD_WIDTH-2:0] circle_radius_reg, circle_radius_next;
    logic [1:0]             cylinder_axis_reg, cylinder_axis_next;

    logic [REC_W-1:0]       rec_in, rec_out;
    logic                   rec_empty, rec_pop;
    logic [CNT_W-1:0]       rec_count;

    always_comb
    begin
        center_first_next  = center_first_reg;
        center_second_next = center_second_reg;
        circle_radius_next = circle_radius_reg;
        cylinder_axis_next = cylinder_axis_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cbb_pkg::REG_CENTER_FIRST:  center_first_next  = cfg_data;
                cbb_pkg::REG_CENTER_SECOND: center_second_next = cfg_data;
                cbb_pkg::REG_CIRCLE_RADIUS: circle_radius_next = cfg_data[COORD_WIDTH-2:0];
                cbb_pkg::REG_CYLINDER_AXIS: cylinder_axis_next = cfg_data[1:0];
                default:                    center_first_next  = center_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_first_reg  <= '0;
            center_second_reg <= '0;
            circle_radius_reg <= '0;
            cylinder_axis_reg <= cbb_pkg::AXIS_Z;
        end
        else
        begin
            center_first_reg  <= center_first_next;
            center_second_reg <= center_second_next;
            circle_radius_reg <= circle_radius_next;
            cylinder_axis_reg <= cylinder_axis_next;
        end
    end

    cbb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .center_first  (center_first_reg),
        .center_second (center_second_reg),
        .circle_radius (circle_radius_reg),
        .cylinder_axis (cylinder_axis_reg),
        .box_x_low     (box_x_low),
        .box_x_high    (box_x_high),
        .box_y_low     (box_y_low),
        .box_y_high    (box_y_high),
        .box_z_low     (box_z_low),
        .box_z_high    (box_z_high),
        .record        (rec_in)
    );

    cbb_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (rec_in),
        .full     (full),
        .pop      (rec_pop),
        .data_out (rec_out),
        .empty    (rec_empty),
        .count    (rec_count)
    );

    cbb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .record        (rec_out),
        .rec_empty     (rec_empty),
        .rec_pop       (rec_pop),
        .circle_radius (circle_radius_reg),
        .empty         (empty),
        .pop           (pop),
        .boundary_hit  (boundary_hit)
    );

`ifndef SYNTH
    a_rec_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count <= CNT_W'(QUEUE_DEPTH))
        else $error("record queue count out of range");

    a_full_blocks_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rec_pop) |=> full)
        else $error("record queue drained without a pop");

    a_axis_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == cbb_pkg::REG_CYLINDER_AXIS)
        |=> (cylinder_axis_reg == $past(cfg_data[1:0])))
        else $error("cylinder axis write lost");
`endif

endmodule

`default_nettype wire

/* verif/circle_box_boundary_test_core_tb.sv */
// testbench for circle_box_boundary_test_core: directed boxes, then random boxes under
// several circle settings; each result checked against a typed value or exact predictor
// depends on cbb_pkg and the rtl/core sources
`default_nettype none

module circle_box_boundary_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;
    typedef struct packed {
        logic [31:0] xl, xh, yl, yh, zl, zh;
    } box_t;
    typedef struct {
        box_t box;
        int   hit;  // typed-in expected value, -1 when the predictor decides
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        push;
    logic        full;
    box_t        drv_box;
    logic        empty;
    logic        pop;
    logic        boundary_hit;

    // register copies used by the predictor
    logic [31:0] cen_a, cen_b;
    logic [30:0] radius;
    logic [1:0]  axis;

    logic hit_q[$];
    int   errors = 0;
    int   boxes_in = 0;
    int   hits_out = 0;
    bit   stall_req = 0;
    int   seen_in, seen_out, idle_cycles;

    circle_box_boundary_test_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .box_x_low   (drv_box.xl),
        .box_x_high  (drv_box.xh),
        .box_y_low   (drv_box.yl),
        .box_y_high  (drv_box.yh),
        .box_z_low   (drv_box.zl),
        .box_z_high  (drv_box.zh),
        .empty       (empty),
        .pop         (pop),
        .boundary_hit(boundary_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic wide_t mulw(longint a, longint b);
        wide_t wa;
        wide_t wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic wide_t sq_dist(longint cx, longint cy, longint x, longint y);
        return mulw(x - cx, x - cx) + mulw(y - cy, y - cy);
    endfunction

    function automatic bit crosses_edge(longint cx, longint cy, longint x1, longint y1,
                                        longint x2, longint y2, wide_t rr);
        longint dx;
        longint dy;
        wide_t  a;
        wide_t  d2;
        wide_t  alpha;
        bit     near, outside, between;
        dx = x2 - x1;
        dy = y2 - y1;
        a = mulw(dy, cx) - mulw(dx, cy) + mulw(x2, y1) - mulw(y2, x1);
        d2 = mulw(dy, dy) + mulw(dx, dx);
        // zero-length edge gives d2 = 0, so near is false
        near = (a * a) < (rr * d2);
        outside = (rr < sq_dist(cx, cy, x1, y1)) || (rr < sq_dist(cx, cy, x2, y2));
        alpha = mulw(x1 - x2, x1 - cx) + mulw(y1 - y2, y1 - cy);
        between = (alpha >= 0) && !(d2 < alpha);
        return near && outside && between;
    endfunction

    function automatic logic boundary_of(box_t b);
        longint lo0, hi0, lo1, hi1, cx, cy, r, px, py;
        wide_t  rr;
        wide_t  q;
        bit     any_in, any_out, enclosed, edge_cross;
        any_in = 0;
        any_out = 0;
        cx = longint'($signed(cen_a));
        cy = longint'($signed(cen_b));
        r = longint'(radius);
        if (axis == cbb_pkg::AXIS_X)
        begin
            lo0 = longint'($signed(b.yl)); hi0 = longint'($signed(b.yh));
            lo1 = longint'($signed(b.zl)); hi1 = longint'($signed(b.zh));
        end
        else if (axis == cbb_pkg::AXIS_Y)
        begin
            lo0 = longint'($signed(b.xl)); hi0 = longint'($signed(b.xh));
            lo1 = longint'($signed(b.zl)); hi1 = longint'($signed(b.zh));
        end
        else
        begin
            // code three acts as z
            lo0 = longint'($signed(b.xl)); hi0 = longint'($signed(b.xh));
            lo1 = longint'($signed(b.yl)); hi1 = longint'($signed(b.yh));
        end
        rr = mulw(r, r);
        for (int i = 0; i < 4; i++)
        begin
            px = i[0] ? lo0 : hi0;
            py = i[1] ? lo1 : hi1;
            q = sq_dist(cx, cy, px, py) - rr;
            if (q < 0)
                any_in = 1;
            else if (q != 0)
                any_out = 1;
        end
        enclosed = (cx - r > lo0) && (cx + r < hi0) && (cy - r > lo1) && (cy + r < hi1);
        edge_cross = crosses_edge(cx, cy, lo0, lo1, lo0, hi1, rr) ||
                     crosses_edge(cx, cy, hi0, lo1, hi0, hi1, rr) ||
                     crosses_edge(cx, cy, lo0, lo1, hi0, lo1, rr) ||
                     crosses_edge(cx, cy, lo0, hi1, hi0, hi1, rr);
        return (any_in && any_out) || enclosed || edge_cross;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            cbb_pkg::REG_CENTER_FIRST:  cen_a = val;
            cbb_pkg::REG_CENTER_SECOND: cen_b = val;
            cbb_pkg::REG_CIRCLE_RADIUS: radius = val[30:0];
            default:                    axis = val[1:0];
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_circle(logic [31:0] ca, logic [31:0] cb, logic [31:0] r,
                              logic [1:0] ax);
        write_reg(cbb_pkg::REG_CENTER_FIRST, ca);
        write_reg(cbb_pkg::REG_CENTER_SECOND, cb);
        write_reg(cbb_pkg::REG_CIRCLE_RADIUS, r);
        write_reg(cbb_pkg::REG_CYLINDER_AXIS, ax);
    endtask

    // sender pause: drop push and wait until every result is back
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (hit_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic send_box(box_t b, int typed_hit);
        bit taken;
        @(negedge clk);
        drv_box <= b;
        push <= 1'b1;
        forever
        begin
            taken = !full;
            @(posedge clk);
            if (taken)
                break;
            @(negedge clk);
        end
        hit_q.push_back(typed_hit < 0 ? boundary_of(b) : logic'(typed_hit[0]));
        boxes_in++;
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) != 0)
            n = 0;
        if (n > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] near_coord(longint base, longint span);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 32'(base + longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    function automatic box_t random_box(longint span);
        box_t b;
        longint c;
        // axis slots of the circle plane get coordinates around the center
        b.xl = near_coord(longint'($signed(axis == cbb_pkg::AXIS_X ? 32'd0 : cen_a)), span);
        b.xh = near_coord(longint'($signed(axis == cbb_pkg::AXIS_X ? 32'd0 : cen_a)), span);
        c = (axis == cbb_pkg::AXIS_X) ? longint'($signed(cen_a)) : longint'($signed(cen_b));
        b.yl = near_coord(c, span);
        b.yh = near_coord(c, span);
        c = (axis == cbb_pkg::AXIS_X || axis == cbb_pkg::AXIS_Y) ? longint'($signed(cen_b)) : 0;
        b.zl = near_coord(c, span);
        b.zh = near_coord(c, span);
        // mostly well-ordered boxes; some left with low above high
        if ($urandom_range(0, 4) != 0)
        begin
            if ($signed(b.xl) > $signed(b.xh)) {b.xl, b.xh} = {b.xh, b.xl};
            if ($signed(b.yl) > $signed(b.yh)) {b.yl, b.yh} = {b.yh, b.yl};
            if ($signed(b.zl) > $signed(b.zh)) {b.zl, b.zh} = {b.zh, b.zl};
        end
        return b;
    endfunction

    // result side: pop driven at the falling edge, transaction checked at the rising edge
    initial
    begin
        int gap;
        int stall_left;
        logic want;
        gap = 0;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 0;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                want = 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                want = 1'b0;
            end
            else
            begin
                want = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(1, 2);
            end
            pop <= want;
            @(posedge clk);
            if (pop && rst_n && !empty)
            begin
                hits_out++;
                if (hit_q.size() == 0)
                begin
                    $display("%0t: result with no box waiting, actual %0b", $time,
                             boundary_hit);
                    errors++;
                end
                else if (hit_q[0] !== boundary_hit)
                begin
                    $display("%0t: boundary_hit mismatch, expected %0b actual %0b", $time,
                             hit_q[0], boundary_hit);
                    errors++;
                    void'(hit_q.pop_front());
                end
                else
                    void'(hit_q.pop_front());
            end
        end
    end

    // watchdog: cycles without any transaction on either side
    initial
    begin
        seen_in = 0;
        seen_out = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (boxes_in != seen_in || hits_out != seen_out)
                idle_cycles = 0;
            else
                idle_cycles++;
            seen_in = boxes_in;
            seen_out = hits_out;
            if (idle_cycles > 5000)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    localparam logic [31:0] MIN_C = 32'h8000_0000;
    localparam logic [31:0] MAX_C = 32'h7fff_ffff;
    localparam logic [31:0] ONE = 32'h0001_0000;

    row_t directed[] = '{
        // zero radius at the origin: strictly inside a box around it
        '{'{-ONE, ONE, -ONE, ONE, 32'd0, 32'd0}, 1},
        '{'{ONE, 2 * ONE, -ONE, ONE, 32'd0, 32'd0}, 0},
        '{'{MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C}, 1},
        '{'{MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C}, 0},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 0},
        '{'{MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C}, 0},
        '{'{MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C}, 0},
        '{'{-ONE, ONE, 32'd0, ONE, 32'd0, 32'd0}, -1},
        '{'{MIN_C, 32'd1, MIN_C, 32'd1, 32'd0, 32'd0}, -1},
        // radius ten below: corners split, edge crossing, degenerate edges
        '{'{-ONE, ONE, -ONE, ONE, 32'd0, 32'd0}, -1},
        '{'{-20 * ONE, 20 * ONE, -20 * ONE, 20 * ONE, 32'd0, 32'd0}, -1},
        '{'{-20 * ONE, 20 * ONE, 5 * ONE, 20 * ONE, 32'd0, 32'd0}, -1},
        '{'{-20 * ONE, 20 * ONE, 5 * ONE, 5 * ONE, 32'd0, 32'd0}, -1},
        '{'{5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 32'd0, 32'd0}, -1},
        '{'{10 * ONE, 10 * ONE, -20 * ONE, 20 * ONE, 32'd0, 32'd0}, -1},
        '{'{2 * ONE, 20 * ONE, -ONE, ONE, 32'd0, 32'd0}, -1},
        '{'{20 * ONE, -20 * ONE, 20 * ONE, -20 * ONE, 32'd0, 32'd0}, -1},
        '{'{-11 * ONE, 11 * ONE, -11 * ONE, 11 * ONE, MIN_C, MAX_C}, -1},
        '{'{MIN_C, MAX_C, 9 * ONE, 20 * ONE, 32'd5, 32'd7}, -1}
    };

    initial
    begin
        longint span;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = cbb_pkg::REG_CENTER_FIRST;
        cfg_data = '0;
        push = 1'b0;
        drv_box = '0;
        cen_a = '0;
        cen_b = '0;
        radius = '0;
        axis = cbb_pkg::AXIS_Z;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting first, then a radius of ten with axis code three
        for (int i = 0; i < 9; i++)
            send_box(directed[i].box, directed[i].hit);
        drain();
        set_circle(32'd0, 32'd0, 10 * ONE, 2'd3);
        for (int i = 9; i < directed.size(); i++)
            send_box(directed[i].box, directed[i].hit);
        drain();
        // extreme settings with extreme boxes
        set_circle(MIN_C, MAX_C, MAX_C, cbb_pkg::AXIS_X);
        for (int i = 2; i < 9; i++)
            send_box(directed[i].box, -1);
        drain();
        set_circle(MAX_C, MIN_C, 32'd0, cbb_pkg::AXIS_Y);
        for (int i = 2; i < 9; i++)
            send_box(directed[i].box, -1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_circle($urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 64)) - 32) <<< 16,
                       $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 64)) - 32) <<< 16,
                       ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 32'h00ff_ffff),
                       2'($urandom_range(0, 3)));
            span = 2 * longint'(radius) + 1000;
            if (ph == 2)
                stall_req = 1;
            for (int i = 0; i < 200; i++)
            begin
                send_box(random_box(span), -1);
                if (ph != 2)
                    sender_gap();
            end
            drain();
        end

        while (hit_q.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* circle_box_boundary_test_core.f */
rtl/core/cbb_pkg.sv
rtl/core/cbb_fifo.sv
rtl/core/cbb_front.sv
rtl/core/cbb_back.sv
rtl/core/circle_box_boundary_test_core.sv
verif/circle_box_boundary_test_core_tb.sv
